// ===== rtl/npcr_pkg.sv =====
// Package for the redmean nearest palette color search.
// Field widths, distance constants, controller states and control structs.
// No dependencies.
package npcr_pkg;

   localparam int KIND_W  = 1;
   localparam int SLOT_W  = 4;
   localparam int COMP_W  = 8;
   localparam int COLOR_W = 3 * COMP_W;
   localparam int CFG_W   = 5;
   localparam int RESET_ENTRIES = 16;

   localparam int RSUM_W = COMP_W + 1;
   localparam int SQ_W   = 2 * COMP_W;
   localparam int WGT_W  = 11;
   localparam int PROD_W = WGT_W + SQ_W;
   localparam int DIST_W = PROD_W + 2;

   localparam int RED_BASE    = 1024;
   localparam int BLUE_BASE   = 1534;
   localparam int GREEN_SHIFT = 11;

   localparam logic [KIND_W-1:0] KIND_WRITE = 1'b0;
   localparam logic [KIND_W-1:0] KIND_QUERY = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic wr_en;
      logic query_load;
      logic rd_en;
      logic rd_first;
      logic rd_last;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/npcr_if.sv =====
// Channel interfaces: palette request, search response, register write.
// Depends on npcr_pkg for field widths.
interface npcr_req_if;
   logic                            valid;
   logic                            ready;
   logic [npcr_pkg::KIND_W-1:0]     kind;
   logic [npcr_pkg::SLOT_W-1:0]     entry_index;
   logic [npcr_pkg::COMP_W-1:0]     red;
   logic [npcr_pkg::COMP_W-1:0]     green;
   logic [npcr_pkg::COMP_W-1:0]     blue;
   modport source (output valid, kind, entry_index, red, green, blue, input ready);
   modport sink   (input valid, kind, entry_index, red, green, blue, output ready);
endinterface

interface npcr_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [npcr_pkg::SLOT_W-1:0]     nearest_index;
   logic                            exact_match;
   modport source (output valid, nearest_index, exact_match, input ready);
   modport sink   (input valid, nearest_index, exact_match, output ready);
endinterface

interface npcr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [npcr_pkg::CFG_W-1:0]      data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/npcr_ctrl.sv =====
// Controller: entries_in_use register, scan address counter and state machine.
// Depends on npcr_pkg and npcr_csr_if.
module npcr_ctrl #(
   parameter int PALETTE_DEPTH = 16,
   localparam int IDX_W = $clog2(PALETTE_DEPTH)
) (
   input  logic                          clock,
   input  logic                          reset,
   npcr_csr_if.sink                      csr,
   input  logic                          req_valid,
   input  logic [npcr_pkg::KIND_W-1:0]   req_kind,
   output logic                          req_ready,
   input  npcr_pkg::status_type          status,
   output npcr_pkg::cmd_type             cmd,
   output logic [IDX_W-1:0]              rd_addr
);

   npcr_pkg::state_type state_ff, state_in;
   logic [npcr_pkg::CFG_W-1:0] entries_ff;
   logic [IDX_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0] last_ff, last_in;
   logic req_xfer;

   assign csr.ready = 1'b1;
   assign req_ready = (state_ff == npcr_pkg::ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rd_addr   = addr_ff;

   always_comb begin
      if (entries_ff == '0) begin
         last_in = '0;
      end else if (int'(entries_ff) >= PALETTE_DEPTH) begin
         last_in = IDX_W'(PALETTE_DEPTH - 1);
      end else begin
         last_in = IDX_W'(entries_ff - npcr_pkg::CFG_W'(1));
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         npcr_pkg::ST_IDLE: begin
            if (req_xfer && req_kind == npcr_pkg::KIND_QUERY) begin
               state_in = npcr_pkg::ST_SCAN;
            end
         end
         npcr_pkg::ST_SCAN: begin
            if (addr_ff == last_ff) begin
               state_in = npcr_pkg::ST_DRAIN;
            end
         end
         npcr_pkg::ST_DRAIN: begin
            if (status.scan_done) begin
               state_in = npcr_pkg::ST_HOLD;
            end
         end
         npcr_pkg::ST_HOLD: begin
            if (status.out_free) begin
               state_in = npcr_pkg::ST_IDLE;
            end
         end
         default: state_in = npcr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd     = '0;
      addr_in = addr_ff;
      case (state_ff)
         npcr_pkg::ST_IDLE: begin
            addr_in        = '0;
            cmd.wr_en      = req_xfer && (req_kind == npcr_pkg::KIND_WRITE);
            cmd.query_load = req_xfer && (req_kind == npcr_pkg::KIND_QUERY);
         end
         npcr_pkg::ST_SCAN: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_first = (addr_ff == '0);
            cmd.rd_last  = (addr_ff == last_ff);
            addr_in      = addr_ff + IDX_W'(1);
         end
         npcr_pkg::ST_HOLD: begin
            cmd.out_load = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= npcr_pkg::ST_IDLE;
         entries_ff <= npcr_pkg::CFG_W'(npcr_pkg::RESET_ENTRIES);
         addr_ff    <= '0;
         last_ff    <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         if (csr.valid) begin
            entries_ff <= csr.data;
         end
         if (cmd.query_load) begin
            last_ff <= last_in;
         end
      end
   end

endmodule

// ===== rtl/npcr_datapath.sv =====
// Datapath: palette memory, pipelined redmean distance unit, running minimum
// and response register. Depends on npcr_pkg.
module npcr_datapath #(
   parameter int PALETTE_DEPTH = 16,
   localparam int IDX_W = $clog2(PALETTE_DEPTH)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  npcr_pkg::cmd_type              cmd,
   output npcr_pkg::status_type           status,
   input  logic [IDX_W-1:0]               rd_addr,
   input  logic [npcr_pkg::SLOT_W-1:0]    req_slot,
   input  logic [npcr_pkg::COLOR_W-1:0]   req_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [npcr_pkg::SLOT_W-1:0]    rsp_index,
   output logic                           rsp_exact
);

   localparam int CW = npcr_pkg::COMP_W;

   logic [npcr_pkg::COLOR_W-1:0] mem [PALETTE_DEPTH];
   logic [npcr_pkg::COLOR_W-1:0] rd_data_ff;
   logic [npcr_pkg::COLOR_W-1:0] query_ff;

   // stage tags
   logic             s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, s5_valid_ff;
   logic             s1_first_ff, s2_first_ff, s3_first_ff, s4_first_ff, s5_first_ff;
   logic             s1_last_ff,  s2_last_ff,  s3_last_ff,  s4_last_ff,  s5_last_ff;
   logic [IDX_W-1:0] s1_idx_ff,   s2_idx_ff,   s3_idx_ff,   s4_idx_ff,   s5_idx_ff;

   logic [CW-1:0] er, eg, eb, qr, qg, qb;
   logic [CW-1:0] dr_ff, dg_ff, db_ff;
   logic [npcr_pkg::RSUM_W-1:0] rsum2_ff, rsum3_ff;
   logic [npcr_pkg::SQ_W-1:0] sqr_ff, sqg_ff, sqb_ff;
   logic [npcr_pkg::WGT_W-1:0] wgt_r, wgt_b;
   logic [npcr_pkg::PROD_W-1:0] pr_ff, pg_ff, pb_ff;
   logic [npcr_pkg::DIST_W-1:0] dist_ff, best_ff;
   logic [IDX_W-1:0] best_idx_ff;
   logic rsp_valid_ff;
   logic [npcr_pkg::SLOT_W-1:0] rsp_index_ff;
   logic rsp_exact_ff;
   logic slot_ok;

   assign slot_ok = (int'(req_slot) < PALETTE_DEPTH);

   always_ff @(posedge clock) begin
      if (cmd.wr_en && slot_ok) begin
         mem[IDX_W'(req_slot)] <= req_color;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign er = rd_data_ff[3*CW-1:2*CW];
   assign eg = rd_data_ff[2*CW-1:CW];
   assign eb = rd_data_ff[CW-1:0];
   assign qr = query_ff[3*CW-1:2*CW];
   assign qg = query_ff[2*CW-1:CW];
   assign qb = query_ff[CW-1:0];

   assign wgt_r = npcr_pkg::WGT_W'(npcr_pkg::RED_BASE)  + npcr_pkg::WGT_W'(rsum3_ff);
   assign wgt_b = npcr_pkg::WGT_W'(npcr_pkg::BLUE_BASE) - npcr_pkg::WGT_W'(rsum3_ff);

   // payload pipeline
   always_ff @(posedge clock) begin
      if (cmd.query_load) begin
         query_ff <= req_color;
      end
      dr_ff    <= (er > qr) ? er - qr : qr - er;
      dg_ff    <= (eg > qg) ? eg - qg : qg - eg;
      db_ff    <= (eb > qb) ? eb - qb : qb - eb;
      rsum2_ff <= npcr_pkg::RSUM_W'(er) + npcr_pkg::RSUM_W'(qr);
      sqr_ff   <= npcr_pkg::SQ_W'(dr_ff) * npcr_pkg::SQ_W'(dr_ff);
      sqg_ff   <= npcr_pkg::SQ_W'(dg_ff) * npcr_pkg::SQ_W'(dg_ff);
      sqb_ff   <= npcr_pkg::SQ_W'(db_ff) * npcr_pkg::SQ_W'(db_ff);
      rsum3_ff <= rsum2_ff;
      pr_ff    <= npcr_pkg::PROD_W'(wgt_r) * npcr_pkg::PROD_W'(sqr_ff);
      pg_ff    <= npcr_pkg::PROD_W'(sqg_ff) << npcr_pkg::GREEN_SHIFT;
      pb_ff    <= npcr_pkg::PROD_W'(wgt_b) * npcr_pkg::PROD_W'(sqb_ff);
      dist_ff  <= npcr_pkg::DIST_W'(pr_ff) + npcr_pkg::DIST_W'(pg_ff)
                + npcr_pkg::DIST_W'(pb_ff);
      s1_first_ff <= cmd.rd_first;
      s1_last_ff  <= cmd.rd_last;
      s1_idx_ff   <= rd_addr;
      s2_first_ff <= s1_first_ff;
      s2_last_ff  <= s1_last_ff;
      s2_idx_ff   <= s1_idx_ff;
      s3_first_ff <= s2_first_ff;
      s3_last_ff  <= s2_last_ff;
      s3_idx_ff   <= s2_idx_ff;
      s4_first_ff <= s3_first_ff;
      s4_last_ff  <= s3_last_ff;
      s4_idx_ff   <= s3_idx_ff;
      s5_first_ff <= s4_first_ff;
      s5_last_ff  <= s4_last_ff;
      s5_idx_ff   <= s4_idx_ff;
      // strict less-than keeps the lowest slot on ties
      if (s5_valid_ff && (s5_first_ff || dist_ff < best_ff)) begin
         best_ff     <= dist_ff;
         best_idx_ff <= s5_idx_ff;
      end
      if (cmd.out_load) begin
         rsp_index_ff <= npcr_pkg::SLOT_W'(best_idx_ff);
         rsp_exact_ff <= (best_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd_en;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.scan_done = s5_valid_ff && s5_last_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_index = rsp_index_ff;
   assign rsp_exact = rsp_exact_ff;

endmodule

// ===== rtl/nearest_palette_color_redmean.sv =====
// Top level of the redmean nearest palette color search.
// Depends on npcr_pkg, npcr_if, npcr_ctrl and npcr_datapath.
//
//   channel  | dir | payload                              | transfer
//   ---------+-----+--------------------------------------+-------------------
//   req_ch   | in  | kind, entry_index, red, green, blue  | valid && ready
//   rsp_ch   | out | nearest_index, exact_match           | valid && ready
//   csr_ch   | in  | data = entries_in_use                | valid (ready = 1)
//
// The palette memory feeds one entry per cycle into a pipelined distance
// unit (absolute differences, squares, weighted products, sum) with a
// running minimum at its end.
// Reset is synchronous and clears control state only; the palette is not
// cleared. A held response does not block palette writes; a query finished
// while the response register is full waits for it to drain.
module nearest_palette_color_redmean #(
   parameter int PALETTE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   npcr_req_if.sink    req_ch,
   npcr_rsp_if.source  rsp_ch,
   npcr_csr_if.sink    csr_ch
);

   localparam int IDX_W = $clog2(PALETTE_DEPTH);

   npcr_pkg::cmd_type    cmd;
   npcr_pkg::status_type status;
   logic [IDX_W-1:0]     rd_addr;

   npcr_ctrl #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ch),
      .req_valid (req_ch.valid),
      .req_kind  (req_ch.kind),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   npcr_datapath #(
      .PALETTE_DEPTH (PALETTE_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .rd_addr   (rd_addr),
      .req_slot  (req_ch.entry_index),
      .req_color ({req_ch.red, req_ch.green, req_ch.blue}),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_index (rsp_ch.nearest_index),
      .rsp_exact (rsp_ch.exact_match)
   );

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.query_load |=> !req_ch.ready)
      else $error("request accepted during a search");

   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      status.scan_done |-> !req_ch.ready)
      else $error("search ended while idle");

   a_load_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_ch.valid)
      else $error("response load lost");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("response overwritten");

endmodule
